// File: sv/cvt_pkg.sv
// Shared types and constants of the cube vertex transform block.
// Holds the channel payload structs, register codes and datapath widths.
// Depends on nothing; every other file uses it by scoped names.
package cvt_pkg;

  localparam int CfgW = 13;
  localparam int CfgIdxW = 1;
  localparam logic [CfgW-1:0] WidthReset = 13'd640;
  localparam logic [CfgW-1:0] HeightReset = 13'd480;

  typedef enum logic [CfgIdxW-1:0] {
    CfgScreenWidth  = 1'b0,
    CfgScreenHeight = 1'b1
  } cfg_reg_e;

  localparam int QueueDepthDef = 2;

  // Datapath widths.
  localparam int FocalW = 28;
  localparam int NumW = 63;
  localparam int DenW = 41;
  localparam int QuotW = 26;
  localparam int QW = QuotW + 2;
  localparam int DivLat = QuotW + 2;

  // Camera and near plane constants in Q16.16.
  localparam int CamZ = 393216;
  localparam int NearLimit = 6553;
  localparam int FocalScale = 21760;

  typedef struct packed {
    logic              alive;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } tf_t;

  typedef struct packed {
    logic [2:0]         corner_index;
    logic signed [23:0] screen_x;
    logic signed [23:0] screen_y;
    logic               visible;
    logic               last_corner;
  } out_item_t;

  typedef struct packed {
    logic valid;
  } queue_ctl_t;

endpackage

// File: sv/cvt_if.sv
// Valid/ready channel interfaces for the transform input and corner output.
// Depends on cvt_pkg for the payload structs.
interface cvt_in_if;
  logic valid;
  logic ready;
  cvt_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface cvt_out_if;
  logic valid;
  logic ready;
  cvt_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// File: sv/cube_vertex_transform_project.sv
// A live transform gives eight corner beats in corner order, one per cycle while
// the output is not stalled; each corner passes stages a to e, the divider and
// the output register. The single corner pipeline walks one transform at a time;
// dead ones are dropped at the input with no beats. Reset is asynchronous and
// active low: queue and pipeline empty, registers at width 640 and height 480.
module cube_vertex_transform_project #(
  parameter int QueueDepth = cvt_pkg::QueueDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  cvt_in_if.sink                      in_i,
  cvt_out_if.source                   out_o,
  input  logic                        cfg_we_i,
  input  logic [cvt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [cvt_pkg::CfgW-1:0]    cfg_data_i
);

  logic [cvt_pkg::CfgW-1:0] width_q, height_q;
  cvt_pkg::queue_ctl_t ctl;
  cvt_pkg::tf_t head;
  logic pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= cvt_pkg::WidthReset;
      height_q <= cvt_pkg::HeightReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cvt_pkg::CfgScreenWidth: width_q <= cfg_data_i;
        cvt_pkg::CfgScreenHeight: height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  cvt_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .pop_i  (pop),
    .ctl_o  (ctl),
    .head_o (head)
  );

  cvt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .head_i       (head),
    .pop_o        (pop),
    .cfg_width_i  (width_q),
    .cfg_height_i (height_q),
    .out_o        (out_o)
  );

endmodule

// File: sv/cvt_front.sv
// Front end: accepts transform beats, drops dead objects, queues live ones.
// Depends on cvt_pkg and cvt_in_if.
module cvt_front #(
  parameter int QueueDepth = cvt_pkg::QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cvt_in_if.sink              in_i,
  input  logic                pop_i,
  output cvt_pkg::queue_ctl_t ctl_o,
  output cvt_pkg::tf_t        head_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QueueDepth);

  cvt_pkg::tf_t mem_q [QueueDepth];
  cvt_pkg::tf_t wr_tf;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic push, pop;

  assign in_i.ready = (cnt_q != FullCnt);
  assign push = in_i.valid && in_i.ready && in_i.data.alive;
  assign pop = pop_i && (cnt_q != '0);

  assign ctl_o.valid = (cnt_q != '0);
  assign head_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_tf.scale_x = in_i.data.scale_x;
    wr_tf.scale_y = in_i.data.scale_y;
    wr_tf.scale_z = in_i.data.scale_z;
    wr_tf.quat_x = in_i.data.quat_x;
    wr_tf.quat_y = in_i.data.quat_y;
    wr_tf.quat_z = in_i.data.quat_z;
    wr_tf.quat_w = in_i.data.quat_w;
    wr_tf.pos_x = in_i.data.pos_x;
    wr_tf.pos_y = in_i.data.pos_y;
    wr_tf.pos_z = in_i.data.pos_z;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_tf;
    end
  end

endmodule

// File: sv/cvt_div.sv
// Pipelined rounding divider: one restoring quotient bit per stage.
// Gives num/den rounded half away from zero, magnitude capped at 2^QuotW.
// Depends on cvt_pkg for widths.
module cvt_div (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [cvt_pkg::NumW-1:0]    num_i,
  input  logic [cvt_pkg::DenW-1:0]           den_i,
  output logic signed [cvt_pkg::QW-1:0]      quo_o
);

  localparam int NW = cvt_pkg::NumW + 1;
  localparam int DW = cvt_pkg::DenW + 1;
  localparam int QB = cvt_pkg::QuotW;
  localparam int RemW = DW + QB;

  logic [cvt_pkg::NumW-2:0] mag;
  logic [NW-1:0] n_q;
  logic [DW-1:0] d0_q;
  logic neg0_q;

  logic [RemW-1:0] rem_q [QB+1];
  logic [QB-1:0] quo_q [QB+1];
  logic [DW-1:0] dd_q [QB+1];
  logic neg_q [QB+1];
  logic ovf_q [QB+1];

  logic [QB:0] qmag;

  assign mag = num_i[cvt_pkg::NumW-1] ? (cvt_pkg::NumW-1)'(-num_i)
                                      : num_i[cvt_pkg::NumW-2:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q <= {mag, 1'b0} + NW'(den_i);
      d0_q <= {den_i, 1'b0};
      neg0_q <= num_i[cvt_pkg::NumW-1];
      rem_q[0] <= RemW'(n_q);
      quo_q[0] <= '0;
      dd_q[0] <= d0_q;
      neg_q[0] <= neg0_q;
      ovf_q[0] <= (RemW'(n_q) >= {d0_q, {QB{1'b0}}});
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_bit
    localparam int Sh = QB - 1 - k;
    logic [RemW-1:0] trial;
    logic take;
    assign trial = RemW'(dd_q[k]) << Sh;
    assign take = (rem_q[k] >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= take ? rem_q[k] - trial : rem_q[k];
        quo_q[k+1] <= quo_q[k] | (take ? (QB'(1) << Sh) : '0);
        dd_q[k+1] <= dd_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign qmag = ovf_q[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, quo_q[QB]};
  assign quo_o = neg_q[QB] ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});

endmodule

// File: sv/cvt_back.sv
// Back end: walks the eight corners of the head transform, rotates,
// translates and projects each one, and holds the result in an output register.
// Depends on cvt_pkg, cvt_out_if and cvt_div.
module cvt_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cvt_pkg::queue_ctl_t       ctl_i,
  input  cvt_pkg::tf_t              head_i,
  output logic                      pop_o,
  input  logic [cvt_pkg::CfgW-1:0]  cfg_width_i,
  input  logic [cvt_pkg::CfgW-1:0]  cfg_height_i,
  cvt_out_if.source                 out_o
);

  localparam int DL = cvt_pkg::DivLat;

  logic en;
  logic issue;
  logic [2:0] corner_q;

  logic signed [16:0] vx, vy, vz;
  logic signed [32:0] m_yz, m_zy, m_zx, m_xz, m_xy, m_yx;

  logic a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q;
  logic [2:0] a_cn_q, b_cn_q, c_cn_q, d_cn_q, e_cn_q;
  cvt_pkg::tf_t a_tf_q, b_tf_q, c_tf_q;
  logic signed [16:0] a_v_q [3];
  logic signed [16:0] b_v_q [3];
  logic signed [34:0] a_t_q [3];
  logic signed [50:0] b_wt_q [3];
  logic signed [51:0] b_cr_q [3];
  logic signed [53:0] c_r_q [3];
  logic signed [33:0] d_w_q [3];
  logic signed [53:0] rr [3];
  logic signed [34:0] depth;
  logic [cvt_pkg::FocalW-1:0] f_q;
  logic signed [cvt_pkg::NumW-1:0] e_nx_q, e_ny_q;
  logic [cvt_pkg::DenW-1:0] e_den_q;
  logic e_vis_q;

  logic sb_vld_q [DL];
  logic [2:0] sb_cn_q [DL];
  logic sb_vis_q [DL];

  logic signed [cvt_pkg::QW-1:0] ox, oy;
  logic signed [29:0] sum_x, sum_y;
  logic out_vld_q;
  cvt_pkg::out_item_t out_q;

  function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
    if (v > 30'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -30'sd8388608) begin
      return 24'sh800000;
    end else begin
      return v[23:0];
    end
  endfunction

  assign en = !out_vld_q || out_o.ready;
  assign issue = en && ctl_i.valid;
  assign pop_o = issue && (corner_q == 3'd7);

  // Corners 1, 2, 5 and 6 sit at positive x; bit 1 selects y, bit 2 selects z.
  always_comb begin
    vx = (corner_q[0] ^ corner_q[1]) ? 17'(head_i.scale_x) : -17'(head_i.scale_x);
    vy = corner_q[1] ? 17'(head_i.scale_y) : -17'(head_i.scale_y);
    vz = corner_q[2] ? 17'(head_i.scale_z) : -17'(head_i.scale_z);
    m_yz = head_i.quat_y * vz;
    m_zy = head_i.quat_z * vy;
    m_zx = head_i.quat_z * vx;
    m_xz = head_i.quat_x * vz;
    m_xy = head_i.quat_x * vy;
    m_yx = head_i.quat_y * vx;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rr[k] = c_r_q[k] + 54'sd1048576;
    end
    depth = 35'(cvt_pkg::CamZ) - 35'(d_w_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_q <= '0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
      for (int k = 0; k < DL; k++) begin
        sb_vld_q[k] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (en) begin
      if (ctl_i.valid) begin
        corner_q <= corner_q + 3'd1;
      end
      a_vld_q <= ctl_i.valid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
      sb_vld_q[0] <= e_vld_q;
      for (int k = 1; k < DL; k++) begin
        sb_vld_q[k] <= sb_vld_q[k-1];
      end
      out_vld_q <= sb_vld_q[DL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    f_q <= cvt_pkg::FocalW'(cfg_height_i) * cvt_pkg::FocalW'(cvt_pkg::FocalScale);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_cn_q <= corner_q;
      a_tf_q <= head_i;
      a_v_q[0] <= vx;
      a_v_q[1] <= vy;
      a_v_q[2] <= vz;
      a_t_q[0] <= (35'(m_yz) - 35'(m_zy)) <<< 1;
      a_t_q[1] <= (35'(m_zx) - 35'(m_xz)) <<< 1;
      a_t_q[2] <= (35'(m_xy) - 35'(m_yx)) <<< 1;

      b_cn_q <= a_cn_q;
      b_tf_q <= a_tf_q;
      for (int k = 0; k < 3; k++) begin
        b_v_q[k] <= a_v_q[k];
        b_wt_q[k] <= a_tf_q.quat_w * a_t_q[k];
      end
      b_cr_q[0] <= 52'(a_tf_q.quat_y * a_t_q[2]) - 52'(a_tf_q.quat_z * a_t_q[1]);
      b_cr_q[1] <= 52'(a_tf_q.quat_z * a_t_q[0]) - 52'(a_tf_q.quat_x * a_t_q[2]);
      b_cr_q[2] <= 52'(a_tf_q.quat_x * a_t_q[1]) - 52'(a_tf_q.quat_y * a_t_q[0]);

      c_cn_q <= b_cn_q;
      c_tf_q <= b_tf_q;
      for (int k = 0; k < 3; k++) begin
        c_r_q[k] <= (54'(b_v_q[k]) <<< 28) + 54'(b_wt_q[k]) + 54'(b_cr_q[k]);
      end

      // Round to Q16.16 with ties toward plus infinity, then translate.
      d_cn_q <= c_cn_q;
      d_w_q[0] <= 34'(rr[0] >>> 21) + 34'(c_tf_q.pos_x);
      d_w_q[1] <= 34'(rr[1] >>> 21) + 34'(c_tf_q.pos_y);
      d_w_q[2] <= 34'(rr[2] >>> 21) + 34'(c_tf_q.pos_z);

      e_cn_q <= d_cn_q;
      e_vis_q <= (depth > 35'(cvt_pkg::NearLimit));
      e_den_q <= cvt_pkg::DenW'(depth[33:0]) * cvt_pkg::DenW'(100);
      e_nx_q <= d_w_q[0] * $signed({1'b0, f_q});
      e_ny_q <= d_w_q[1] * $signed({1'b0, f_q});

      sb_cn_q[0] <= e_cn_q;
      sb_vis_q[0] <= e_vis_q;
      for (int k = 1; k < DL; k++) begin
        sb_cn_q[k] <= sb_cn_q[k-1];
        sb_vis_q[k] <= sb_vis_q[k-1];
      end

      out_q.corner_index <= sb_cn_q[DL-1];
      out_q.last_corner <= (sb_cn_q[DL-1] == 3'd7);
      out_q.visible <= sb_vis_q[DL-1];
      out_q.screen_x <= sb_vis_q[DL-1] ? sat24(sum_x) : '0;
      out_q.screen_y <= sb_vis_q[DL-1] ? sat24(sum_y) : '0;
    end
  end

  cvt_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (e_nx_q),
    .den_i (e_den_q),
    .quo_o (ox)
  );

  cvt_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (e_ny_q),
    .den_i (e_den_q),
    .quo_o (oy)
  );

  assign sum_x = $signed(30'({cfg_width_i, 7'b0})) + 30'(ox);
  assign sum_y = $signed(30'({cfg_height_i, 7'b0})) - 30'(oy);

  assign out_o.valid = out_vld_q;
  assign out_o.data = out_q;

  a_corner_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> corner_q == $past(corner_q) + 3'd1)
    else $error("corner counter did not advance on issue");

  a_corner_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !issue |=> corner_q == $past(corner_q))
    else $error("corner counter moved without issue");

  a_hidden_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_q.visible |-> out_q.screen_x == '0 && out_q.screen_y == '0)
    else $error("hidden corner carries nonzero coordinates");

endmodule
